>>> rtl/tcp_pkg.sv
// Shared types, character codes and command codes for the tuning command parser.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package tcp_pkg;

  localparam int HEAD_DEPTH  = 3;
  localparam int FIELD_DEPTH = 6;
  localparam int VALUE_W     = 23;

  // Character codes
  localparam logic [7:0] CH_END   = 8'h21;  // '!'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_LP    = 8'h70;  // 'p'
  localparam logic [7:0] CH_LE    = 8'h65;  // 'e'
  localparam logic [7:0] CH_LO    = 8'h6F;  // 'o'
  localparam logic [7:0] CH_LS    = 8'h73;  // 's'

  // Value-carrying field lengths, the saturated field length and the full head count
  localparam logic [2:0] LEN_4   = 3'd4;
  localparam logic [2:0] LEN_5   = 3'd5;
  localparam logic [2:0] LEN_6   = 3'd6;
  localparam logic [2:0] LEN_SAT = 3'd7;
  localparam logic [1:0] HEAD_FULL = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_POS_KP     = 4'd1,
    CMD_POS_KI     = 4'd2,
    CMD_POS_KD     = 4'd3,
    CMD_SPD_KP     = 4'd4,
    CMD_SPD_KI     = 4'd5,
    CMD_SPD_KD     = 4'd6,
    CMD_TARGET_SPD = 4'd7,
    CMD_TARGET_POS = 4'd8
  } cmd_t;

  // Message state seen by the decoder
  typedef struct packed {
    logic [HEAD_DEPTH-1:0][7:0]  head_bytes;
    logic [1:0]                  head_count;
    logic [FIELD_DEPTH-1:0][7:0] field_bytes;
    logic [2:0]                  field_count;
    logic                        negative;
  } msg_state_t;

endpackage

>>> rtl/tcp_msg_state.sv
// Per-message state of the parser: head bytes, value field bytes, counts, sign.
// Depends on tcp_pkg.
module tcp_msg_state (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_take,
  input  logic [7:0]          rx_byte,
  output tcp_pkg::msg_state_t state
);

  tcp_pkg::msg_state_t state_r;
  tcp_pkg::msg_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    if (byte_take) begin
      if (rx_byte == tcp_pkg::CH_END) begin
        state_nxt = '0;
      end else begin
        if (state_r.head_count != tcp_pkg::HEAD_FULL) begin
          for (int i = 0; i < tcp_pkg::HEAD_DEPTH; i++) begin
            if (state_r.head_count == 2'(i)) state_nxt.head_bytes[i] = rx_byte;
          end
          state_nxt.head_count = state_r.head_count + 2'd1;
        end
        if (rx_byte == tcp_pkg::CH_EQ) begin
          state_nxt.field_count = '0;
          state_nxt.negative    = 1'b0;
        end else if (rx_byte == tcp_pkg::CH_MINUS && state_r.field_count == '0 &&
                     !state_r.negative) begin
          state_nxt.negative = 1'b1;
        end else if (state_r.field_count < tcp_pkg::LEN_6) begin
          for (int i = 0; i < tcp_pkg::FIELD_DEPTH; i++) begin
            if (state_r.field_count == 3'(i)) state_nxt.field_bytes[i] = rx_byte;
          end
          state_nxt.field_count = state_r.field_count + 3'd1;
        end else begin
          state_nxt.field_count = tcp_pkg::LEN_SAT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

>>> rtl/tcp_decode.sv
// Command and value decode from the held message state.
// Depends on tcp_pkg.
module tcp_decode (
  input  tcp_pkg::msg_state_t              state,
  output tcp_pkg::cmd_t                    command,
  output logic signed [tcp_pkg::VALUE_W-1:0] value
);

  localparam int SUM_W = tcp_pkg::VALUE_W + 1;

  logic [7:0] a, b, c;
  logic signed [SUM_W-1:0] d [tcp_pkg::FIELD_DEPTH];
  logic signed [SUM_W-1:0] mag;
  logic signed [SUM_W-1:0] sgn;

  assign a = state.head_bytes[0];
  assign b = state.head_bytes[1];
  assign c = state.head_bytes[2];

  always_comb begin
    if      (a == tcp_pkg::CH_P && b == tcp_pkg::CH_1) command = tcp_pkg::CMD_POS_KP;
    else if (a == tcp_pkg::CH_I && b == tcp_pkg::CH_1) command = tcp_pkg::CMD_POS_KI;
    else if (a == tcp_pkg::CH_D && b == tcp_pkg::CH_1) command = tcp_pkg::CMD_POS_KD;
    else if (a == tcp_pkg::CH_P && b == tcp_pkg::CH_2) command = tcp_pkg::CMD_SPD_KP;
    else if (a == tcp_pkg::CH_I && b == tcp_pkg::CH_2) command = tcp_pkg::CMD_SPD_KI;
    else if (a == tcp_pkg::CH_D && b == tcp_pkg::CH_2) command = tcp_pkg::CMD_SPD_KD;
    else if (a == tcp_pkg::CH_S && b == tcp_pkg::CH_LP && c == tcp_pkg::CH_LE)
      command = tcp_pkg::CMD_TARGET_SPD;
    else if (a == tcp_pkg::CH_P && b == tcp_pkg::CH_LO && c == tcp_pkg::CH_LS)
      command = tcp_pkg::CMD_TARGET_POS;
    else command = tcp_pkg::CMD_NONE;
  end

  // Digits are not range checked: any byte counts as byte minus '0'
  always_comb begin
    for (int i = 0; i < tcp_pkg::FIELD_DEPTH; i++) begin
      d[i] = $signed({{(SUM_W-8){1'b0}}, state.field_bytes[i]})
           - $signed({{(SUM_W-8){1'b0}}, tcp_pkg::CH_ZERO});
    end
  end

  always_comb begin
    case (state.field_count)
      tcp_pkg::LEN_4: mag = SUM_W'(100) * d[0] + SUM_W'(10) * d[2] + d[3];
      tcp_pkg::LEN_5: mag = SUM_W'(1000) * d[0] + SUM_W'(100) * d[1]
                          + SUM_W'(10) * d[3] + d[4];
      tcp_pkg::LEN_6: mag = SUM_W'(10000) * d[0] + SUM_W'(1000) * d[1]
                          + SUM_W'(100) * d[2] + SUM_W'(10) * d[4] + d[5];
      default:        mag = '0;
    endcase
    sgn = state.negative ? -mag : mag;
  end

  assign value = sgn[tcp_pkg::VALUE_W-1:0];

endmodule

>>> rtl/tuning_command_parser_core.sv
// Top level of the tuning command parser: input register, message state, decode,
// result register. Depends on tcp_pkg, tcp_msg_state and tcp_decode.
//
// Parses ASCII tuning commands such as "P1=1.23!" one byte per transaction.
// Each '!' produces exactly one result transaction carrying the command code
// decoded from the first three message bytes and the value after the last '='
// in hundredths (signed, zero unless the field holds 4, 5 or 6 bytes). Other
// bytes produce no result. The block takes one byte every cycle unless in_stall
// holds it. out_valid rises once the '!' has moved from the input register
// through decode into the result register; the '!' can wait in the input
// register while the sink stalls. in_stall rises only while a '!' waits in
// the input register and the result register still holds a result that the
// sink is stalling.
module tuning_command_parser_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [3:0]                          out_command,
  output logic signed [tcp_pkg::VALUE_W-1:0]  out_value_hundredths
);

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // Result register
  logic                               out_valid_r;
  logic [3:0]                         out_command_r;
  logic signed [tcp_pkg::VALUE_W-1:0] out_value_r;

  logic                               is_end;
  logic                               out_free;
  logic                               byte_take;
  tcp_pkg::msg_state_t                state;
  tcp_pkg::cmd_t                      dec_command;
  logic signed [tcp_pkg::VALUE_W-1:0] dec_value;

  assign is_end    = (in_byte_r == tcp_pkg::CH_END);
  // Result register can take a new result when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;
  // Ordinary bytes always advance; a terminator needs room for its result
  assign byte_take = in_valid_r && (!is_end || out_free);
  // Hold the input register only when its byte cannot advance
  assign in_stall  = in_valid_r && !byte_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  tcp_msg_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .rx_byte   (in_byte_r),
    .state     (state)
  );

  // Decode reads the state before the terminator clears it
  tcp_decode u_decode (
    .state   (state),
    .command (dec_command),
    .value   (dec_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= byte_take && is_end;
    end
  end

  // Load a fresh result only on a terminator; otherwise hold the payload
  always_ff @(posedge clk) begin
    if (byte_take && is_end) begin
      out_command_r <= dec_command;
      out_value_r   <= dec_value;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_command          = out_command_r;
  assign out_value_hundredths = out_value_r;

endmodule

>>> sim/tb_tuning_command_parser_core.sv
// Self-checking testbench for tuning_command_parser_core: byte stream in, one
// command/value result per '!' out. Depends on tcp_pkg and the rtl/ sources only.
module tb_tuning_command_parser_core;
  import tcp_pkg::*;

  // One pending input transaction; a drain entry holds the sender until every
  // predicted result has been received.
  typedef struct packed {
    logic       drain;
    logic [7:0] b;
  } rx_item_t;

  // One predicted result transaction.
  typedef struct packed {
    logic [3:0]                cmd;
    logic signed [VALUE_W-1:0] value;
  } cmd_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_LONG
  } stall_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                in_rx_byte = 8'h00;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [3:0]                out_command;
  logic signed [VALUE_W-1:0] out_value_hundredths;

  rx_item_t    rx_pending_q[$];
  cmd_result_t cmd_result_q[$];
  int          err_count = 0;

  // Shadow of the parser's message state
  logic [7:0] head_q[HEAD_DEPTH];
  logic [1:0] head_cnt;
  logic [7:0] field_q[FIELD_DEPTH];
  logic [2:0] field_cnt;
  logic       neg_flag;

  // Sender burst shaping and receiver stall pattern
  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;

  string head_list[10] = '{"P1", "I1", "D1", "P2", "I2", "D2", "Spe", "Pos", "Spx", "Po"};

  tuning_command_parser_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_command          (out_command),
    .out_value_hundredths (out_value_hundredths)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Clear the shadow message state, as after reset and after every '!'.
  function automatic void clear_message();
    for (int i = 0; i < HEAD_DEPTH; i++) head_q[i] = 8'h00;
    for (int i = 0; i < FIELD_DEPTH; i++) field_q[i] = 8'h00;
    head_cnt  = '0;
    field_cnt = '0;
    neg_flag  = 1'b0;
  endfunction

  function automatic int digit_at(int idx);
    return int'(field_q[idx]) - int'(CH_ZERO);
  endfunction

  // Advance the shadow state by one accepted byte; on '!' queue the result
  // that the parser must produce.
  function automatic void parse_rx_byte(logic [7:0] b);
    cmd_result_t res;
    int          v;
    if (b == CH_END) begin
      // First match wins, as in the decoder table
      if (head_q[0] == CH_P && head_q[1] == CH_1) res.cmd = CMD_POS_KP;
      else if (head_q[0] == CH_I && head_q[1] == CH_1) res.cmd = CMD_POS_KI;
      else if (head_q[0] == CH_D && head_q[1] == CH_1) res.cmd = CMD_POS_KD;
      else if (head_q[0] == CH_P && head_q[1] == CH_2) res.cmd = CMD_SPD_KP;
      else if (head_q[0] == CH_I && head_q[1] == CH_2) res.cmd = CMD_SPD_KI;
      else if (head_q[0] == CH_D && head_q[1] == CH_2) res.cmd = CMD_SPD_KD;
      else if (head_q[0] == CH_S && head_q[1] == CH_LP && head_q[2] == CH_LE)
        res.cmd = CMD_TARGET_SPD;
      else if (head_q[0] == CH_P && head_q[1] == CH_LO && head_q[2] == CH_LS)
        res.cmd = CMD_TARGET_POS;
      else res.cmd = CMD_NONE;
      // Skip the byte at the point position; other lengths give zero
      v = 0;
      if (field_cnt == LEN_4)
        v = 100 * digit_at(0) + 10 * digit_at(2) + digit_at(3);
      else if (field_cnt == LEN_5)
        v = 1000 * digit_at(0) + 100 * digit_at(1) + 10 * digit_at(3) + digit_at(4);
      else if (field_cnt == LEN_6)
        v = 10000 * digit_at(0) + 1000 * digit_at(1) + 100 * digit_at(2)
            + 10 * digit_at(4) + digit_at(5);
      if (neg_flag) v = -v;
      res.value = v[VALUE_W-1:0];
      cmd_result_q.push_back(res);
      clear_message();
    end else begin
      if (head_cnt < HEAD_FULL) begin
        head_q[head_cnt] = b;
        head_cnt++;
      end
      if (b == CH_EQ) begin
        // a new '=' restarts the field
        field_cnt = '0;
        neg_flag  = 1'b0;
      end else if (b == CH_MINUS && field_cnt == 0 && !neg_flag) begin
        neg_flag = 1'b1;
      end else if (field_cnt < LEN_6) begin
        field_q[field_cnt] = b;
        field_cnt++;
      end else begin
        field_cnt = LEN_SAT;
      end
    end
  endfunction

  function automatic void push_byte(logic [7:0] b);
    rx_item_t item;
    item.drain = 1'b0;
    item.b     = b;
    rx_pending_q.push_back(item);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_drain();
    rx_item_t item;
    item.drain = 1'b1;
    item.b     = 8'h00;
    rx_pending_q.push_back(item);
  endfunction

  // Build one message: mostly well-formed commands with random content, the
  // rest broken heads, odd field lengths, raw bytes and noise.
  function automatic void push_random_message();
    int len;
    int fill_mode;
    int sel;
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes of any value, then the terminator
      len = $urandom_range(0, 12);
      for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
      push_byte(CH_END);
      return;
    end
    sel = $urandom_range(0, 11);
    if (sel < 10) begin
      push_text(head_list[sel]);
    end else if (sel == 10) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
    end
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      push_byte(CH_EQ);
    end else if (sel == 8) begin
      // an earlier field that a second '=' discards
      push_byte(CH_EQ);
      push_byte(8'($urandom_range(0, 255)));
      push_byte(CH_EQ);
    end
    if ($urandom_range(0, 9) < 3) push_byte(CH_MINUS);
    if ($urandom_range(0, 9) == 0) push_byte(CH_MINUS);
    if ($urandom_range(0, 9) < 7) len = $urandom_range(4, 6);
    else len = $urandom_range(0, 9);
    sel = $urandom_range(0, 19);
    if (sel < 15) fill_mode = 0;
    else if (sel < 18) fill_mode = 1;
    else fill_mode = sel - 16;
    for (int i = 0; i < len; i++) begin
      case (fill_mode)
        0: begin
          if (i == len - 3) push_byte(8'h2E);
          else push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        1: push_byte(8'($urandom_range(0, 255)));
        2: push_byte(8'hFF);
        default: push_byte(8'h00);
      endcase
    end
    push_byte(CH_END);
  endfunction

  // Driver: present pending bytes in bursts, hold a stalled transaction, and
  // stop at a drain entry until the result queue is empty.
  always @(posedge clk) begin : drive_proc
    rx_item_t item;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'h00;
    end else begin
      if (in_valid && !in_stall) parse_rx_byte(in_rx_byte);
      if (in_valid && in_stall) begin
        // hold the stalled transaction as it is
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (rx_pending_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (rx_pending_q[0].drain) begin
        in_valid <= 1'b0;
        if (cmd_result_q.size() == 0) void'(rx_pending_q.pop_front());
      end else begin
        item = rx_pending_q.pop_front();
        in_valid   <= 1'b1;
        in_rx_byte <= item.b;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: pick a new random stall pattern whenever the current one runs out.
  always @(posedge clk) begin : stall_proc
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((mode_left % 32) < 24);
      endcase
    end
  end

  // Monitor: compare every accepted result transaction with the oldest prediction.
  always @(posedge clk) begin : check_proc
    cmd_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_result_q.size() == 0) begin
        $error("unexpected result: command %0d, value_hundredths %0d",
               out_command, out_value_hundredths);
        err_count++;
      end else begin
        want = cmd_result_q.pop_front();
        if (out_command !== want.cmd) begin
          $error("command mismatch: expected %0d, actual %0d", want.cmd, out_command);
          err_count++;
        end
        if (out_value_hundredths !== want.value) begin
          $error("value_hundredths mismatch: expected %0d, actual %0d",
                 want.value, out_value_hundredths);
          err_count++;
        end
      end
    end
  end

  initial begin
    clear_message();
    // Directed: empty message, leading minus with length 4, a restarted field
    // of length 6 under an unknown head, and the byte extremes in a short field.
    push_text("!");
    push_text("D2=-9.99!");
    push_text("P=1=123.45!");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(CH_END);
    push_drain();
    while (rx_pending_q.size() < 1575) begin
      push_random_message();
      if ((rx_pending_q.size() % 500) < 10) push_drain();
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (rx_pending_q.size() != 0 || in_valid || cmd_result_q.size() != 0)
      @(posedge clk);
    // let any stray result surface
    repeat (10) @(posedge clk);
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> tuning_command_parser_core.f
rtl/tcp_pkg.sv
rtl/tcp_msg_state.sv
rtl/tcp_decode.sv
rtl/tuning_command_parser_core.sv
sim/tb_tuning_command_parser_core.sv
